@@ rtl/itda_pkg.sv @@
`default_nettype none

package itda_pkg;

	// fixed width of the value field on the input channel
	localparam int FIELD_BITS = 64;

	// default conversion width
	localparam int VALUE_BITS_DEF = 64;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	// decimal digits needed for a bits-wide unsigned value: floor(bits*log10(2)) + 1
	function automatic int num_digits(input int bits);
		return (bits * 30103) / 100000 + 1;
	endfunction

endpackage

`default_nettype wire

@@ rtl/itda_front.sv @@
`default_nettype none

module itda_front #(
	parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire logic [itda_pkg::FIELD_BITS-1:0] value_bits,
	input  wire logic                            is_signed,
	input  wire logic                            full,
	output logic                                 push,
	output logic      [VALUE_BITS:0]             push_data
);
	import itda_pkg::*;

	logic [VALUE_BITS-1:0] raw;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;

	// bits above the width are dropped
	assign raw = value_bits[VALUE_BITS-1:0];
	assign neg = is_signed & raw[VALUE_BITS-1];
	// the most negative value negates to itself, which read unsigned is its magnitude
	assign mag = neg ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

	assign item_ready = ~full;
	assign push       = item_valid & ~full;
	assign push_data  = {neg, mag};

endmodule

`default_nettype wire

@@ rtl/itda_queue.sv @@
`default_nettype none

module itda_queue #(
	parameter int WIDTH = itda_pkg::VALUE_BITS_DEF + 1,
	parameter int DEPTH = itda_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	output logic                  pop_valid,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data
);
	import itda_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign do_pop    = pop & pop_valid;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || do_pop))
		else $error("queue written while full");

endmodule

`default_nettype wire

@@ rtl/itda_back.sv @@
`default_nettype none

module itda_back #(
	parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  pop_valid,
	input  wire logic [VALUE_BITS:0]   pop_data,
	output logic                       pop,
	output logic                       char_valid,
	input  wire logic                  char_ready,
	output logic      [7:0]            ascii_char,
	output logic                       last_char
);
	import itda_pkg::*;

	localparam int ND = num_digits(VALUE_BITS);
	localparam int BW = 4 * ND;
	localparam int CW = $clog2(VALUE_BITS + 1);
	localparam int RW = $clog2(ND + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BW-1:0]         bcd_q;
	logic [CW-1:0]         bit_cnt_q;
	logic [RW-1:0]         rem_q;
	logic                  started_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic [BW-1:0] bcd_adj;
	logic [3:0]    top_digit;
	logic          slot_free;
	logic          skip_zero;
	logic          load_char;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < ND; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end
		end
	end

	assign top_digit  = bcd_q[BW-1 -: 4];
	assign slot_free  = ~out_valid_q | char_ready;
	assign skip_zero  = ~started_q & (top_digit == 4'd0) & (rem_q != RW'(1));
	// a new character goes into the output register this cycle
	assign load_char  = slot_free & ((state_q == ST_SIGN)
		| ((state_q == ST_EMIT) & ~skip_zero));
	assign pop        = (state_q == ST_IDLE);
	assign char_valid = out_valid_q;
	assign ascii_char = char_q;
	assign last_char  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			bin_q       <= '0;
			bcd_q       <= '0;
			bit_cnt_q   <= '0;
			rem_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (load_char) begin
				out_valid_q <= 1'b1;
			end else if (char_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						neg_q     <= pop_data[VALUE_BITS];
						bin_q     <= pop_data[VALUE_BITS-1:0];
						bcd_q     <= '0;
						bit_cnt_q <= CW'(VALUE_BITS);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q     <= {bcd_adj[BW-2:0], bin_q[VALUE_BITS-1]};
					bin_q     <= {bin_q[VALUE_BITS-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == CW'(1)) begin
						rem_q     <= RW'(ND);
						started_q <= 1'b0;
						state_q   <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						char_q  <= ASCII_MINUS;
						last_q  <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (skip_zero) begin
						bcd_q <= {bcd_q[BW-5:0], 4'd0};
						rem_q <= rem_q - 1'b1;
					end else if (slot_free) begin
						char_q    <= ASCII_ZERO + {4'd0, top_digit};
						last_q    <= (rem_q == RW'(1));
						started_q <= 1'b1;
						bcd_q     <= {bcd_q[BW-5:0], 4'd0};
						rem_q     <= rem_q - 1'b1;
						if (rem_q == RW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (char_q == ASCII_MINUS
			|| (char_q >= ASCII_ZERO && char_q <= ASCII_ZERO + 8'd9)))
		else $error("character is neither a digit nor a minus");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && char_q == ASCII_MINUS) |-> !last_q)
		else $error("minus sign marked as last character");

	a_conv_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV) |-> (bit_cnt_q != '0))
		else $error("conversion running with empty bit count");

endmodule

`default_nettype wire

@@ rtl/integer_to_decimal_ascii.sv @@
`default_nettype none

// Binary integer to decimal ASCII. Each input word carries a value and a
// signed flag; only the low VALUE_BITS bits of the value are used. The block
// emits the decimal text one character per output word, most significant
// digit first, leading zeros suppressed, a lone '0' for zero and a leading
// '-' for a negative signed value (the most negative value prints its full
// magnitude). last_char marks the final character. Steps per number: it is
// taken from the queue, converted by shift-and-add-3 over all VALUE_BITS
// bits, given a minus sign when present, then each decimal digit position
// (num_digits(VALUE_BITS), 20 at 64 bits) is stepped through whether the
// digit is a suppressed leading zero or is emitted; an output stall holds
// the sign and the emitted digits. A two-word queue sits behind the input,
// so up to two numbers are taken while the converter is busy.

module integer_to_decimal_ascii #(
	parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire logic [itda_pkg::FIELD_BITS-1:0] value_bits,
	input  wire logic                            is_signed,
	output logic                                 char_valid,
	input  wire logic                            char_ready,
	output logic      [7:0]                      ascii_char,
	output logic                                 last_char
);
	import itda_pkg::*;

	// queue word: sign flag over magnitude
	logic                  push;
	logic [VALUE_BITS:0]   push_data;
	logic                  full;
	logic                  pop_valid;
	logic                  pop;
	logic [VALUE_BITS:0]   pop_data;

	// front: masks to width, picks sign, takes the magnitude
	itda_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.value_bits (value_bits),
		.is_signed  (is_signed),
		.full       (full),
		.push       (push),
		.push_data  (push_data)
	);

	itda_queue #(
		.WIDTH (VALUE_BITS + 1),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data)
	);

	// back: bit-serial BCD conversion, then character output register
	itda_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop        (pop),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

endmodule

`default_nettype wire
